// ----- rtl/sha1_block_hasher_defines.svh -----
// Assertion macros for the SHA-1 block hasher checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SHA1_BLOCK_HASHER_DEFINES_SVH
`define SHA1_BLOCK_HASHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1BH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1BH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sha1bh_pkg.sv -----
// Shared types, constants and helper functions for the SHA-1 block hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package sha1bh_pkg;

	localparam int unsigned DigestWords = 5;
	localparam int unsigned Rounds      = 80;
	localparam int unsigned QuarterLen  = 20;
	localparam int unsigned WindowDepth = 16;

	typedef logic [31:0] word_t;

	localparam word_t IvWords [DigestWords] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [1:0] QtrChoose   = 2'd0;
	localparam logic [1:0] QtrParityLo = 2'd1;
	localparam logic [1:0] QtrMajority = 2'd2;
	localparam logic [1:0] QtrParityHi = 2'd3;

	typedef struct packed {
		logic       load_word;
		logic       reload_iv;
		logic       load_vars;
		logic       round_en;
		logic [1:0] quarter;
		logic       add_chain;
		logic [2:0] emit_idx;
	} cmd_t;

	function automatic word_t round_const(input logic [1:0] quarter);
		word_t k;
		case (quarter)
			QtrChoose:   k = 32'h5a827999;
			QtrParityLo: k = 32'h6ed9eba1;
			QtrMajority: k = 32'h8f1bbcdc;
			QtrParityHi: k = 32'hca62c1d6;
			default:     k = 32'h5a827999;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/sha1bh_ctrl.sv -----
// Controller for the SHA-1 block hasher: word counting, round sequencing and digest output.
// Depends on sha1bh_pkg; drives the datapath through a cmd_t command bundle.
`timescale 1ns / 1ps

module sha1bh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	input  logic              start_message,
	input  logic              end_message,
	output logic              msg_stall,
	output logic              digest_valid,
	input  logic              digest_stall,
	output logic              digest_last,
	output sha1bh_pkg::cmd_t  cmd
);
	import sha1bh_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [6:0] LastRound = 7'(Rounds - 1);
	localparam logic [2:0] LastEmit  = 3'(DigestWords - 1);
	localparam logic [3:0] LastWord  = 4'(WindowDepth - 1);

	logic [1:0] state_q;
	logic [3:0] wcnt_q;
	logic [6:0] rnd_q;
	logic [2:0] emit_q;
	logic       end_pend_q;
	logic       accept;
	logic       wrap;
	logic [1:0] quarter;

	assign accept = msg_valid && (state_q == ST_IDLE);
	assign wrap   = accept && !start_message && (wcnt_q == LastWord);

	always_comb begin
		if (rnd_q < 7'(QuarterLen)) begin
			quarter = QtrChoose;
		end else if (rnd_q < 7'(2 * QuarterLen)) begin
			quarter = QtrParityLo;
		end else if (rnd_q < 7'(3 * QuarterLen)) begin
			quarter = QtrMajority;
		end else begin
			quarter = QtrParityHi;
		end
	end

	assign msg_stall    = (state_q != ST_IDLE);
	assign digest_valid = (state_q == ST_EMIT);
	assign digest_last  = (state_q == ST_EMIT) && (emit_q == LastEmit);

	always_comb begin
		cmd.load_word = accept;
		cmd.reload_iv = accept && start_message;
		cmd.load_vars = wrap;
		cmd.round_en  = (state_q == ST_ROUND);
		cmd.quarter   = quarter;
		cmd.add_chain = (state_q == ST_FINAL);
		cmd.emit_idx  = emit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wcnt_q     <= '0;
			rnd_q      <= '0;
			emit_q     <= '0;
			end_pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						end_pend_q <= end_message;
						rnd_q      <= '0;
						emit_q     <= '0;
						if (end_message) begin
							wcnt_q <= '0;
						end else if (start_message) begin
							wcnt_q <= 4'd1;
						end else begin
							wcnt_q <= wcnt_q + 4'd1;
						end
						if (wrap) begin
							state_q <= ST_ROUND;
						end else if (end_message) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LastRound) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					state_q <= end_pend_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (!digest_stall) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == LastEmit) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/sha1bh_datapath.sv -----
// Datapath for the SHA-1 block hasher: chaining words, working words and schedule window.
// Depends on sha1bh_pkg; every action is ordered by the controller's cmd_t bundle.
`timescale 1ns / 1ps

module sha1bh_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1bh_pkg::cmd_t  cmd,
	input  sha1bh_pkg::word_t message_word,
	output sha1bh_pkg::word_t digest_word
);
	import sha1bh_pkg::*;

	word_t chain_q [DigestWords];
	word_t vars_q  [DigestWords];
	word_t win_q   [WindowDepth];

	word_t expand;
	word_t expand_rot;
	word_t shift_in;
	word_t f_val;
	word_t new_a;

	assign expand     = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign expand_rot = {expand[30:0], expand[31]};
	assign shift_in   = cmd.load_word ? message_word : expand_rot;

	always_comb begin
		case (cmd.quarter)
			QtrChoose:   f_val = (vars_q[1] & vars_q[2]) | (~vars_q[1] & vars_q[3]);
			QtrMajority: f_val = (vars_q[1] & vars_q[2]) | (vars_q[1] & vars_q[3])
				| (vars_q[2] & vars_q[3]);
			default:     f_val = vars_q[1] ^ vars_q[2] ^ vars_q[3];
		endcase
	end

	assign new_a = {vars_q[0][26:0], vars_q[0][31:27]} + f_val + vars_q[4]
		+ round_const(cmd.quarter) + win_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DigestWords; i++) begin
				chain_q[i] <= IvWords[i];
				vars_q[i]  <= '0;
			end
		end else begin
			if (cmd.reload_iv) begin
				for (int i = 0; i < DigestWords; i++) begin
					chain_q[i] <= IvWords[i];
				end
			end else if (cmd.add_chain) begin
				for (int i = 0; i < DigestWords; i++) begin
					chain_q[i] <= chain_q[i] + vars_q[i];
				end
			end
			if (cmd.load_vars) begin
				for (int i = 0; i < DigestWords; i++) begin
					vars_q[i] <= chain_q[i];
				end
			end else if (cmd.round_en) begin
				vars_q[0] <= new_a;
				vars_q[1] <= vars_q[0];
				vars_q[2] <= {vars_q[1][1:0], vars_q[1][31:2]};
				vars_q[3] <= vars_q[2];
				vars_q[4] <= vars_q[3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word || cmd.round_en) begin
			for (int i = 0; i < WindowDepth - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WindowDepth - 1] <= shift_in;
		end
	end

	always_comb begin
		digest_word = '0;
		if (cmd.emit_idx < 3'(DigestWords)) begin
			digest_word = chain_q[cmd.emit_idx];
		end
	end

endmodule

// ----- rtl/sha1_block_hasher.sv -----
// Top level of the SHA-1 block hasher for already padded messages.
// Depends on sha1bh_pkg, sha1bh_ctrl and sha1bh_datapath.
//
//   Channel  Direction  Handshake                  Payload
//   msg      in         msg_valid / msg_stall      message_word, start_message, end_message
//   digest   out        digest_valid / digest_stall digest_word, digest_last
//
// A word that closes neither a block nor a message is taken without raising msg_stall.
// The sixteenth word of a block runs 80 rounds on one shared round unit and then the chaining
// add; the block takes no new word until these are done.
// A final word leads to five digest items, one per cycle while digest_stall is low.
// msg_stall is high from the cycle after a block's sixteenth word until the chaining add is done,
// and from the cycle after a final word until the last digest item is taken.
// Reset restores the SHA-1 initial chaining words; no clearing pass is needed.
`timescale 1ns / 1ps

module sha1_block_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  sha1bh_pkg::word_t message_word,
	input  logic              start_message,
	input  logic              end_message,
	output logic              digest_valid,
	input  logic              digest_stall,
	output sha1bh_pkg::word_t digest_word,
	output logic              digest_last
);
	import sha1bh_pkg::*;

	cmd_t cmd;

	sha1bh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_valid     (msg_valid),
		.start_message (start_message),
		.end_message   (end_message),
		.msg_stall     (msg_stall),
		.digest_valid  (digest_valid),
		.digest_stall  (digest_stall),
		.digest_last   (digest_last),
		.cmd           (cmd)
	);

	sha1bh_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_word (message_word),
		.digest_word  (digest_word)
	);

endmodule

// ----- rtl/sha1bh_checker.sv -----
// Port-level checker for the SHA-1 block hasher, bound to the top level.
// Depends on sha1bh_pkg and the assertion macros in sha1_block_hasher_defines.svh.
`timescale 1ns / 1ps
`include "sha1_block_hasher_defines.svh"

module sha1bh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              msg_valid,
	input logic              msg_stall,
	input sha1bh_pkg::word_t message_word,
	input logic              start_message,
	input logic              end_message,
	input logic              digest_valid,
	input logic              digest_stall,
	input sha1bh_pkg::word_t digest_word,
	input logic              digest_last
);
	import sha1bh_pkg::*;

	`SHA1BH_ASSERT_NEXT(a_msg_hold, msg_valid && msg_stall, msg_valid && $stable({message_word, start_message, end_message}), "stalled message item changed")
	`SHA1BH_ASSERT_NEXT(a_digest_hold, digest_valid && digest_stall, digest_valid && $stable(digest_word) && $stable(digest_last), "stalled digest item changed")
	`SHA1BH_ASSERT_SAME(a_no_input_while_emit, digest_valid, msg_stall, "input taken while digest is emitted")
	`SHA1BH_ASSERT_SAME(a_first_not_last, $rose(digest_valid), !digest_last, "digest began with its last item")
	`SHA1BH_ASSERT_NEXT(a_stop_after_last, digest_valid && !digest_stall && digest_last, !digest_valid, "digest ran past its fifth item")

endmodule

bind sha1_block_hasher sha1bh_checker u_sha1bh_checker (.*);

// ----- verif/sha1_block_hasher_tb.sv -----
// Self-checking testbench for the SHA-1 block hasher: drives message words with random
// gaps and digest stalls and checks every digest item against a SHA-1 model or the IV.
// Depends on sha1bh_pkg and sha1_block_hasher.
`timescale 1ns / 1ps

module sha1_block_hasher_tb;

	import sha1bh_pkg::word_t;

	typedef struct {
		word_t word;
		logic  is_last;
	} digest_item_t;

	typedef struct {
		word_t word;
		bit    start_msg;
		bit    end_msg;
		bit    iv_digest;
	} dir_row_t;

	typedef enum {
		MsgWellFormed,
		MsgContinued,
		MsgTruncated,
		MsgRestarted,
		MsgSingle,
		MsgNoise
	} msg_kind_t;

	localparam word_t InitChain [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};
	localparam word_t RoundK [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};
	localparam int RandomItems = 100;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  msg_valid = 1'b0;
	logic  msg_stall;
	word_t message_word = '0;
	logic  start_message = 1'b0;
	logic  end_message = 1'b0;
	logic  digest_valid;
	logic  digest_stall = 1'b0;
	word_t digest_word;
	logic  digest_last;

	word_t        chain_words [5] = InitChain;
	word_t        sched_window [16];
	logic [3:0]   word_pos = '0;
	digest_item_t pending_digest [$];
	int           error_count = 0;
	int           items_sent = 0;
	bit           burst_mode = 1'b0;

	// Rows without a typed digest are checked against the model below.
	dir_row_t dir_table [22] = '{
		'{32'hffffffff, 1'b0, 1'b1, 1'b1},
		'{32'h00000000, 1'b1, 1'b1, 1'b1},
		'{32'h61626380, 1'b1, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000018, 1'b0, 1'b1, 1'b0},
		'{32'hffffffff, 1'b1, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b1, 1'b0, 1'b0},
		'{32'h12345678, 1'b0, 1'b1, 1'b1}
	};

	sha1_block_hasher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.message_word (message_word),
		.start_message(start_message),
		.end_message  (end_message),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.digest_last  (digest_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t random_word();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic sha1_compress();
		word_t w [16];
		word_t a, b, c, d, e, f, sum, x;
		w = sched_window;
		a = chain_words[0];
		b = chain_words[1];
		c = chain_words[2];
		d = chain_words[3];
		e = chain_words[4];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				x = w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15];
				w[t & 15] = {x[30:0], x[31]};
			end
			if (t < 20)
				f = (b & c) | (~b & d);
			else if (t < 40 || t >= 60)
				f = b ^ c ^ d;
			else
				f = (b & c) | (b & d) | (c & d);
			sum = {a[26:0], a[31:27]} + f + e + RoundK[t / 20] + w[t & 15];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		chain_words[0] += a;
		chain_words[1] += b;
		chain_words[2] += c;
		chain_words[3] += d;
		chain_words[4] += e;
	endtask

	task automatic expect_digest(input word_t words [5]);
		for (int k = 0; k < 5; k++)
			pending_digest.push_back('{words[k], k == 4});
	endtask

	task automatic sha1_absorb(input word_t w, input bit s, input bit e, input bit predict);
		if (s) begin
			chain_words = InitChain;
			word_pos = '0;
		end
		sched_window[word_pos] = w;
		word_pos = word_pos + 4'd1;
		if (word_pos == 4'd0)
			sha1_compress();
		if (e) begin
			word_pos = '0;
			if (predict)
				expect_digest(chain_words);
		end
	endtask

	task automatic send_word(input word_t w, input bit s, input bit e);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap != 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		message_word <= w;
		start_message <= s;
		end_message <= e;
		do @(posedge clk); while (msg_stall !== 1'b0);
		items_sent++;
	endtask

	task automatic hash_word(input word_t w, input bit s, input bit e);
		send_word(w, s, e);
		sha1_absorb(w, s, e, 1'b1);
	endtask

	task automatic random_message();
		msg_kind_t kind;
		int        r, nwords, restart_at;
		bit        s, e;
		r = $urandom_range(0, 99);
		restart_at = 0;
		if (r < 55)
			kind = MsgWellFormed;
		else if (r < 65)
			kind = MsgContinued;
		else if (r < 78)
			kind = MsgTruncated;
		else if (r < 88)
			kind = MsgRestarted;
		else if (r < 94)
			kind = MsgSingle;
		else
			kind = MsgNoise;
		burst_mode = ($urandom_range(0, 3) == 0);
		case (kind)
			MsgWellFormed: begin
				nwords = ($urandom_range(0, 4) == 0) ? 32 : 16;
			end
			MsgContinued: begin
				nwords = 16;
			end
			MsgTruncated: begin
				nwords = $urandom_range(1, 31);
				if (nwords == 16)
					nwords = 15;
			end
			MsgRestarted: begin
				restart_at = $urandom_range(1, 15);
				nwords = restart_at + 16;
			end
			MsgSingle: begin
				nwords = 1;
			end
			default: begin
				nwords = $urandom_range(1, 8);
			end
		endcase
		for (int i = 0; i < nwords; i++) begin
			if (kind == MsgNoise) begin
				s = ($urandom_range(0, 7) == 0);
				e = ($urandom_range(0, 7) == 0);
			end else begin
				s = (i == 0 && kind != MsgContinued) || (kind == MsgRestarted && i == restart_at);
				e = (i == nwords - 1);
			end
			hash_word(random_word(), s, e);
		end
	endtask

	task automatic report_mismatch(input string what, input digest_item_t want);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s: expected %08h last %0b, got %08h last %0b", $realtime, what,
				want.word, want.is_last, digest_word, digest_last);
	endtask

	always @(posedge clk) begin
		digest_item_t want;
		if (arst_n && digest_valid === 1'b1 && digest_stall == 1'b0) begin
			if (pending_digest.size() == 0) begin
				report_mismatch("digest item with none pending", '{'0, 1'b0});
			end else begin
				want = pending_digest.pop_front();
				if (digest_word !== want.word || digest_last !== want.is_last)
					report_mismatch("digest item mismatch", want);
			end
		end
	end

	initial begin
		int open_run, hold;
		@(posedge arst_n);
		forever begin
			open_run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 150)
				: $urandom_range(1, 6);
			repeat (open_run) begin
				@(posedge clk);
				digest_stall <= 1'b0;
			end
			hold = pick_gap();
			repeat (hold) begin
				@(posedge clk);
				digest_stall <= 1'b1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_table[r]) begin
			send_word(dir_table[r].word, dir_table[r].start_msg, dir_table[r].end_msg);
			sha1_absorb(dir_table[r].word, dir_table[r].start_msg, dir_table[r].end_msg,
				!dir_table[r].iv_digest);
			if (dir_table[r].iv_digest && dir_table[r].end_msg)
				expect_digest(InitChain);
		end
		while (items_sent < $size(dir_table) + RandomItems)
			random_message();
		msg_valid <= 1'b0;
		while (pending_digest.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (error_count == 0)
			$display("sha1_block_hasher_tb: clean");
		else
			$display("sha1_block_hasher_tb: errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("sha1_block_hasher_tb: errors");
		$finish;
	end

endmodule
